FILE: rtl/bra_pkg.sv
// Shared constants and controller/datapath interface types for the run allocator.
`default_nettype none

package bra_pkg;

  // Map storage word: sixteen allocation units per memory word.
  localparam int WORD_BITS  = 16;
  localparam int WORD_SHIFT = 4;

  // Request actions.
  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_FREE    = 2'd1;
  localparam logic [1:0] ACT_REALLOC = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_BAD_RANGE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_req;
    logic       clr_write;
    logic       addr_zero;
    logic       addr_inc;
    logic       range_free;
    logic       scan_init;
    logic       scan_eval;
    logic       rmw_clear;
    logic       rmw_set;
    logic       code_load;
    logic [1:0] code;
    logic       res_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] act;
    logic       req_ok;
    logic       clr_last;
    logic       rmw_last;
    logic       scan_hit;
    logic       scan_last;
    logic       res_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/bitmap_run_allocator.sv
// Top level of the first-fit bitmap run allocator.
`default_nettype none

// First-fit run allocator over a bitmap of MAP_UNITS units, sixteen units to a
// memory word. Each input word is one request (allocate, free, or free then
// allocate) and yields exactly one result word with a status, the start of the
// allocated run and the free count after the request. After reset the block
// runs a clearing pass, writing one map word a cycle, and holds in_ready low
// until it is done. One request is in progress at a time. A request is first
// taken and checked. A free then primes the map read and clears the range
// one map word at a time; an allocation primes the read, scans map words from
// unit 0 until the first run that fits, then primes the read again and marks
// each word that the run covers; a reallocate does the free and then the
// allocation. A final step posts the result, waiting while the output
// register still holds an earlier one. A finished result sits in an output
// register, so the next request is taken while the previous result waits for
// out_ready. A bad operand (zero count, range past the end, unknown action)
// reports bad_range and changes nothing; an allocation that finds no run
// reports no_space and leaves the map alone, though the free half of a
// reallocate stays done.
module bitmap_run_allocator #(
  parameter int MAP_UNITS = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] action,
  input  wire logic [7:0] start_index,
  input  wire logic [8:0] count,
  input  wire logic [8:0] realloc_count,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      status,
  output logic [7:0]      first_index,
  output logic [8:0]      free_units
);

  bra_pkg::cmd_t cmd;
  bra_pkg::sts_t sts;

  // The controller sequences each request; the datapath owns the map and counters.
  bra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bra_datapath #(
    .MAP_UNITS (MAP_UNITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .action        (action),
    .start_index   (start_index),
    .count         (count),
    .realloc_count (realloc_count),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .status        (status),
    .first_index   (first_index),
    .free_units    (free_units)
  );

endmodule

`default_nettype wire

FILE: rtl/bra_ctrl.sv
// Request sequencer of the run allocator: clearing pass, free, scan and mark phases.
`default_nettype none

module bra_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bra_pkg::sts_t sts,
  output bra_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_CLEAR      = 4'd0;
  localparam logic [3:0] S_IDLE       = 4'd1;
  localparam logic [3:0] S_CHECK      = 4'd2;
  localparam logic [3:0] S_FREE_PRIME = 4'd3;
  localparam logic [3:0] S_FREE_RUN   = 4'd4;
  localparam logic [3:0] S_SCAN_PRIME = 4'd5;
  localparam logic [3:0] S_SCAN_RUN   = 4'd6;
  localparam logic [3:0] S_MARK_PRIME = 4'd7;
  localparam logic [3:0] S_MARK_RUN   = 4'd8;
  localparam logic [3:0] S_DONE       = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.req_ok) begin
          cmd.code_load = 1'b1;
          cmd.code      = bra_pkg::ST_BAD_RANGE;
          state_next    = S_DONE;
        end else if (sts.act == bra_pkg::ACT_ALLOC) begin
          cmd.addr_zero = 1'b1;
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN_PRIME;
        end else begin
          cmd.range_free = 1'b1;
          state_next     = S_FREE_PRIME;
        end
      end
      S_FREE_PRIME: begin
        cmd.addr_inc = 1'b1;
        state_next   = S_FREE_RUN;
      end
      S_FREE_RUN: begin
        cmd.rmw_clear = 1'b1;
        cmd.addr_inc  = 1'b1;
        if (sts.rmw_last) begin
          if (sts.act == bra_pkg::ACT_REALLOC) begin
            cmd.addr_zero = 1'b1;
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN_PRIME;
          end else begin
            cmd.code_load = 1'b1;
            cmd.code      = bra_pkg::ST_OK;
            state_next    = S_DONE;
          end
        end
      end
      S_SCAN_PRIME: begin
        cmd.addr_inc = 1'b1;
        state_next   = S_SCAN_RUN;
      end
      S_SCAN_RUN: begin
        cmd.scan_eval = 1'b1;
        cmd.addr_inc  = 1'b1;
        if (sts.scan_hit) begin
          state_next = S_MARK_PRIME;
        end else if (sts.scan_last) begin
          cmd.code_load = 1'b1;
          cmd.code      = bra_pkg::ST_NO_SPACE;
          state_next    = S_DONE;
        end
      end
      S_MARK_PRIME: begin
        cmd.addr_inc = 1'b1;
        state_next   = S_MARK_RUN;
      end
      S_MARK_RUN: begin
        cmd.rmw_set  = 1'b1;
        cmd.addr_inc = 1'b1;
        if (sts.rmw_last) begin
          cmd.code_load = 1'b1;
          cmd.code      = bra_pkg::ST_OK;
          state_next    = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.res_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/bra_datapath.sv
// Map memory, word scanner, range read-modify-write and result register of the allocator.
`default_nettype none

module bra_datapath #(
  parameter int MAP_UNITS = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bra_pkg::cmd_t cmd,
  output bra_pkg::sts_t      sts,
  input  wire logic [1:0]    action,
  input  wire logic [7:0]    start_index,
  input  wire logic [8:0]    count,
  input  wire logic [8:0]    realloc_count,
  input  wire logic          out_ready,
  output logic               out_valid,
  output logic [1:0]         status,
  output logic [7:0]         first_index,
  output logic [8:0]         free_units
);

  localparam int WB    = bra_pkg::WORD_BITS;
  localparam int WS    = bra_pkg::WORD_SHIFT;
  localparam int WORDS = (MAP_UNITS + WB - 1) / WB;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IW    = AW + WS;
  localparam int FW    = $clog2(MAP_UNITS + 1);
  localparam int RW    = FW + 1;
  localparam int LW    = $clog2(WB + 1);

  function automatic logic [LW-1:0] pop_word(input logic [WB-1:0] v);
    logic [LW-1:0] s;
    s = '0;
    for (int i = 0; i < WB; i++) begin
      s = s + LW'(v[i]);
    end
    return s;
  endfunction

  // Request registers.
  logic [1:0] act_q;
  logic [7:0] start_q;
  logic [8:0] n_q;
  logic [8:0] rn_q;

  // Map memory and its read pipeline.
  logic [WB-1:0] map_mem [WORDS];
  logic [WB-1:0] rd_data;
  logic [AW-1:0] addr;
  logic [AW-1:0] word_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [WB-1:0] wr_data;

  // Range and scan state.
  logic [IW-1:0] lo;
  logic [IW-1:0] hi;
  logic [RW-1:0] r;
  logic [IW-1:0] head_c;
  logic [IW-1:0] head_q;
  logic [FW-1:0] free_total;
  logic [1:0]    code_q;

  // Result register.
  logic          res_valid;
  logic [1:0]    res_status;
  logic [7:0]    res_first;
  logic [8:0]    res_free;

  // Combinational helpers.
  logic [8:0]    alen;
  logic [31:0]   alen32;
  logic [31:0]   n32;
  logic [31:0]   rn32;
  logic [31:0]   start32;
  logic [31:0]   end32;
  logic [31:0]   end_m1;
  logic          free_ok;
  logic          alloc_ok;
  logic          realloc_ok;
  logic          req_ok;
  logic [IW-1:0] base;
  logic [WB-1:0] view;
  logic [WB-1:0] rmask;
  logic [31:0]   k32;
  logic [31:0]   km32;
  logic [31:0]   nm32;
  logic          carry_hit;
  logic [WB-1:0] win;
  logic [WB-1:0] lowest;
  logic [WS-1:0] widx;
  logic          win_hit;
  logic          scan_hit;
  logic [IW-1:0] found_head;
  logic [LW-1:0] tail_free;
  logic [LW-1:0] flipped;
  logic [31:0]   head32;
  logic [31:0]   free32;

  assign alen    = (act_q == bra_pkg::ACT_ALLOC) ? n_q : rn_q;
  assign alen32  = {23'd0, alen};
  assign n32     = {23'd0, n_q};
  assign rn32    = {23'd0, rn_q};
  assign start32 = {24'd0, start_q};
  assign end32   = start32 + n32;
  assign end_m1  = end32 - 32'd1;

  assign free_ok    = (n_q != 9'd0) && (end32 <= 32'(MAP_UNITS));
  assign alloc_ok   = (n_q != 9'd0) && (n32 <= 32'(MAP_UNITS));
  assign realloc_ok = (rn_q != 9'd0) && (rn32 <= 32'(MAP_UNITS));

  always_comb begin
    case (act_q)
      bra_pkg::ACT_ALLOC:   req_ok = alloc_ok;
      bra_pkg::ACT_FREE:    req_ok = free_ok;
      bra_pkg::ACT_REALLOC: req_ok = free_ok && realloc_ok;
      default:              req_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      act_q   <= action;
      start_q <= start_index;
      n_q     <= count;
      rn_q    <= realloc_count;
    end
  end

  // Unit index of bit 0 of the word now on the read port.
  assign base = {word_q, {WS{1'b0}}};

  // Units past the end of the map read as used; range mask of the current operation.
  always_comb begin
    for (int j = 0; j < WB; j++) begin
      view[j]  = rd_data[j] | ~((32'(base) + 32'(j)) < 32'(MAP_UNITS));
      rmask[j] = ((32'(base) + 32'(j)) >= 32'(lo)) && ((32'(base) + 32'(j)) <= 32'(hi));
    end
  end

  // A run carried in from earlier words completes here when its remaining
  // length fits in the free low bits of this word.
  assign k32       = alen32 - 32'(r);
  assign km32      = (32'd1 << k32[4:0]) - 32'd1;
  assign carry_hit = (k32 <= 32'(WB)) && ((view & km32[WB-1:0]) == '0);

  // Runs that start and end inside this word.
  assign nm32 = (32'd1 << alen32[4:0]) - 32'd1;
  always_comb begin
    for (int i = 0; i < WB; i++) begin
      win[i] = ((alen32 + 32'(i)) <= 32'(WB)) &&
               (((nm32 << i) & {{(32 - WB){1'b0}}, view}) == 32'd0);
    end
  end

  assign lowest  = win & (~win + 1'b1);
  assign win_hit = |win;

  always_comb begin
    widx = '0;
    for (int i = 0; i < WB; i++) begin
      widx = widx | (lowest[i] ? WS'(i) : '0);
    end
  end

  assign scan_hit = carry_hit || win_hit;

  always_comb begin
    if (carry_hit) begin
      found_head = (r == '0) ? base : head_c;
    end else begin
      found_head = base + IW'(widx);
    end
  end

  // Free units at the top of the word, carried into the next word.
  always_comb begin
    tail_free = '0;
    for (int i = 1; i <= WB; i++) begin
      tail_free = tail_free + LW'((view >> (WB - i)) == '0);
    end
  end

  assign flipped = cmd.rmw_set ? pop_word(~rd_data & rmask) : pop_word(rd_data & rmask);

  assign wr_en   = cmd.clr_write || cmd.rmw_clear || cmd.rmw_set;
  assign wr_addr = cmd.clr_write ? addr : word_q;
  assign wr_data = cmd.clr_write ? '0 :
                   cmd.rmw_set   ? (rd_data | rmask) : (rd_data & ~rmask);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rd_data <= map_mem[addr];
    word_q  <= addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else if (cmd.scan_eval && scan_hit) begin
      addr <= found_head[IW-1:WS];
    end else if (cmd.range_free) begin
      addr <= start32[IW-1:WS];
    end else if (cmd.addr_zero) begin
      addr <= '0;
    end else if (cmd.addr_inc || cmd.clr_write) begin
      addr <= addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.range_free) begin
      lo <= start32[IW-1:0];
      hi <= end_m1[IW-1:0];
    end else if (cmd.scan_eval && scan_hit) begin
      lo     <= found_head;
      hi     <= found_head + alen32[IW-1:0] - 1'b1;
      head_q <= found_head;
    end
    if (cmd.scan_init) begin
      r <= '0;
    end else if (cmd.scan_eval && !scan_hit) begin
      if (view == '0) begin
        r <= r + RW'(WB);
        if (r == '0) begin
          head_c <= base;
        end
      end else begin
        r      <= RW'(tail_free);
        head_c <= base + IW'(WB) - IW'(tail_free);
      end
    end
    if (cmd.code_load) begin
      code_q <= cmd.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_total <= FW'(MAP_UNITS);
    end else if (cmd.rmw_clear) begin
      free_total <= free_total + FW'(flipped);
    end else if (cmd.rmw_set) begin
      free_total <= free_total - FW'(flipped);
    end
  end

  assign head32 = 32'(head_q);
  assign free32 = 32'(free_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_load) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
    if (cmd.res_load) begin
      res_status <= code_q;
      res_first  <= ((code_q == bra_pkg::ST_OK) && (act_q != bra_pkg::ACT_FREE)) ?
                    head32[7:0] : 8'd0;
      res_free   <= free32[8:0];
    end
  end

  assign out_valid   = res_valid;
  assign status      = res_status;
  assign first_index = res_first;
  assign free_units  = res_free;

  assign sts.act       = act_q;
  assign sts.req_ok    = req_ok;
  assign sts.clr_last  = (addr == AW'(WORDS - 1));
  assign sts.rmw_last  = (word_q == hi[IW-1:WS]);
  assign sts.scan_hit  = scan_hit;
  assign sts.scan_last = (word_q == AW'(WORDS - 1));
  assign sts.res_free  = !res_valid || out_ready;

`ifndef SYNTHESIS
  a_mark_only_free: assert property (@(posedge clk) disable iff (rst)
    cmd.rmw_set |-> ((rd_data & rmask) == '0))
    else $error("allocated run overlaps units already in use");

  a_hit_in_map: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_eval && scan_hit) |-> ((32'(found_head) + alen32) <= 32'(MAP_UNITS)))
    else $error("found run extends past the end of the map");

  a_run_below_len: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_eval |-> (32'(r) < alen32))
    else $error("carried run reached the requested length without a hit");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.rmw_clear |=> ((free_total >= $past(free_total)) &&
                       (32'(free_total) <= 32'(MAP_UNITS))))
    else $error("free count out of range after a release");
`endif

endmodule

`default_nettype wire
